### hw/rtl/assert_macros.svh
// Assertion shorthands; every user has clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define RLBP_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define RLBP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RLBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rlbp_pkg.sv
`default_nettype none

package rlbp_pkg;

    localparam int TOP_INDEX_DEFAULT = 63;
    localparam int MAX_CHARS_DEFAULT = 1023;

    localparam int MAP_W    = 64;
    localparam int OFF_W    = 10;
    localparam int OFF_MAX  = 1023;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_X  = 8'h78;

    localparam logic [4:0] DIGIT_NONE = 5'd16;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BACKWARD = 2'd1;
    localparam logic [1:0] ST_TOO_HIGH = 2'd2;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_START  = 7'b0000010,
        PH_SEP    = 7'b0000100,
        PH_ZERO   = 7'b0001000,
        PH_X      = 7'b0010000,
        PH_DIGITS = 7'b0100000,
        PH_UPPRE  = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

    typedef struct packed {
        logic       first_char;
        logic [7:0] char_code;
    } char_req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [MAP_W-1:0] stave_map;
        logic [OFF_W-1:0] end_offset;
    } map_req_t;

    // Digit value in base 16, DIGIT_NONE when not a digit.
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        d = DIGIT_NONE;
        if (c inside {[CH_0:CH_9]}) begin
            d = 5'(c - CH_0);
        end else if (c inside {[CH_LC_A:CH_LC_F]}) begin
            d = 5'(c - CH_LC_A) + 5'd10;
        end else if (c inside {[CH_UC_A:CH_UC_F]}) begin
            d = 5'(c - CH_UC_A) + 5'd10;
        end
        return d;
    endfunction

    // Status of a finished entry from its bounds.
    function automatic logic [1:0] close_status(
        input logic       upper,
        input logic       negative,
        input logic [7:0] value,
        input logic [7:0] lower,
        input logic [7:0] top
    );
        logic [1:0] s;
        logic [7:0] low;
        low = upper ? lower : value;
        s = ST_OK;
        if (upper && negative && (value != 8'd0)) begin
            s = ST_BACKWARD;
        end else if (upper && (value < low)) begin
            s = ST_BACKWARD;
        end else if (value > top) begin
            s = ST_TOO_HIGH;
        end
        return s;
    endfunction

    // Bits lo..hi set; both are at most 63 where used.
    function automatic logic [MAP_W-1:0] range_mask(
        input logic [5:0] lo,
        input logic [5:0] hi
    );
        logic [MAP_W-1:0] ones;
        ones = '1;
        return (ones >> (6'd63 - hi)) & (ones << lo);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/rlbp_core.sv
`default_nettype none

module rlbp_core #(
    parameter int TOP_INDEX = rlbp_pkg::TOP_INDEX_DEFAULT,
    parameter int MAX_CHARS = rlbp_pkg::MAX_CHARS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire rlbp_pkg::char_req_t req,
    output logic                     push,
    output rlbp_pkg::map_req_t       result
);

    localparam int CW = $clog2(MAX_CHARS + 1);
    localparam int PW = (CW > rlbp_pkg::OFF_W) ? CW : rlbp_pkg::OFF_W;

    rlbp_pkg::phase_t                 phase_reg, phase_next;
    logic [7:0]                       number_reg, number_next;
    rlbp_pkg::radix_t                 radix_reg, radix_next;
    logic                             negative_reg, negative_next;
    logic [7:0]                       lower_reg, lower_next;
    logic [rlbp_pkg::MAP_W-1:0]       bitmap_reg, bitmap_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic                             upper_reg, upper_next;
    logic                             sign_reg, sign_next;
    logic                             clean_reg, clean_next;
    logic [CW-1:0]                    stop_reg, stop_next;

    logic [7:0]  c;
    logic [CW-1:0] pos;
    logic [4:0]  d;
    logic [4:0]  radix_val;
    logic [11:0] scaled;
    logic [12:0] acc;
    logic        do_emit, do_post, do_sep, do_begin, do_close;
    logic        begin_upper, after_x, after_upper;
    logic [1:0]  emit_status, close_st;
    logic [CW-1:0] emit_pos;
    logic [PW-1:0] emit_pos_w;

    always_comb
    begin
        c             = req.char_code;
        phase_next    = phase_reg;
        number_next   = number_reg;
        radix_next    = radix_reg;
        negative_next = negative_reg;
        lower_next    = lower_reg;
        bitmap_next   = bitmap_reg;
        count_next    = count_reg;
        upper_next    = upper_reg;
        sign_next     = sign_reg;
        clean_next    = clean_reg;
        stop_next     = stop_reg;
        do_emit       = 1'b0;
        do_post       = 1'b0;
        do_sep        = 1'b0;
        do_begin      = 1'b0;
        do_close      = 1'b0;
        begin_upper   = 1'b0;
        after_x       = 1'b0;
        after_upper   = 1'b0;
        emit_status   = rlbp_pkg::ST_OK;
        emit_pos      = '0;
        close_st      = rlbp_pkg::ST_OK;
        d             = rlbp_pkg::digit_of(c);
        radix_val     = 5'd10;
        scaled        = '0;
        acc           = '0;

        // A first character restarts the list from a clean state.
        if (req.first_char)
        begin
            phase_next    = rlbp_pkg::PH_START;
            number_next   = '0;
            radix_next    = rlbp_pkg::RADIX_DEC;
            negative_next = 1'b0;
            lower_next    = '0;
            bitmap_next   = '0;
            count_next    = '0;
            upper_next    = 1'b0;
            sign_next     = 1'b0;
            clean_next    = 1'b1;
            stop_next     = '0;
        end

        pos = count_next;

        if (phase_next != rlbp_pkg::PH_IDLE)
        begin
            if (count_next < CW'(MAX_CHARS))
            begin
                count_next = count_next + CW'(1);
            end

            case (phase_next)
                rlbp_pkg::PH_START:
                begin
                    if (c inside {[rlbp_pkg::CH_0:rlbp_pkg::CH_9]})
                    begin
                        do_begin = 1'b1;
                    end
                    else
                    begin
                        do_emit  = 1'b1;
                        emit_pos = pos;
                    end
                end
                rlbp_pkg::PH_SEP:
                begin
                    do_sep = 1'b1;
                end
                rlbp_pkg::PH_ZERO:
                begin
                    if (c == rlbp_pkg::CH_LC_X || c == rlbp_pkg::CH_UC_X)
                    begin
                        phase_next = rlbp_pkg::PH_X;
                    end
                    else if (c inside {[rlbp_pkg::CH_0:rlbp_pkg::CH_7]})
                    begin
                        radix_next  = rlbp_pkg::RADIX_OCT;
                        number_next = c - rlbp_pkg::CH_0;
                        phase_next  = rlbp_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        do_post = 1'b1;
                    end
                end
                rlbp_pkg::PH_X:
                begin
                    if (d != rlbp_pkg::DIGIT_NONE)
                    begin
                        radix_next  = rlbp_pkg::RADIX_HEX;
                        number_next = {4'd0, d[3:0]};
                        phase_next  = rlbp_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        number_next = '0;
                        do_close    = 1'b1;
                        after_x     = 1'b1;
                    end
                end
                rlbp_pkg::PH_DIGITS:
                begin
                    case (radix_next)
                        rlbp_pkg::RADIX_HEX:
                        begin
                            radix_val = 5'd16;
                            scaled    = {number_next, 4'd0};
                        end
                        rlbp_pkg::RADIX_OCT:
                        begin
                            radix_val = 5'd8;
                            scaled    = {1'b0, number_next, 3'd0};
                        end
                        default:
                        begin
                            radix_val = 5'd10;
                            scaled    = {1'b0, number_next, 3'd0} + {3'd0, number_next, 1'b0};
                        end
                    endcase
                    if (d < radix_val)
                    begin
                        acc         = {1'b0, scaled} + {8'd0, d};
                        number_next = (acc > 13'd255) ? 8'd255 : acc[7:0];
                    end
                    else
                    begin
                        do_post = 1'b1;
                    end
                end
                rlbp_pkg::PH_UPPRE:
                begin
                    if (!sign_next && (c == rlbp_pkg::CH_SPACE ||
                        c inside {[rlbp_pkg::CH_TAB:rlbp_pkg::CH_CR]}))
                    begin
                        if (c != rlbp_pkg::CH_SPACE && clean_next)
                        begin
                            clean_next = 1'b0;
                            stop_next  = pos;
                        end
                    end
                    else if (!sign_next && (c == rlbp_pkg::CH_PLUS || c == rlbp_pkg::CH_DASH))
                    begin
                        sign_next     = 1'b1;
                        negative_next = (c == rlbp_pkg::CH_DASH);
                        if (clean_next)
                        begin
                            clean_next = 1'b0;
                            stop_next  = pos;
                        end
                    end
                    else if (c inside {[rlbp_pkg::CH_0:rlbp_pkg::CH_9]})
                    begin
                        do_begin    = 1'b1;
                        begin_upper = 1'b1;
                    end
                    else
                    begin
                        // Empty upper bound reads as zero.
                        number_next   = '0;
                        negative_next = 1'b0;
                        do_close      = 1'b1;
                        after_upper   = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = rlbp_pkg::PH_IDLE;
                end
            endcase

            if (do_post)
            begin
                if (!upper_next && c == rlbp_pkg::CH_DASH)
                begin
                    lower_next    = number_next;
                    upper_next    = 1'b1;
                    negative_next = 1'b0;
                    sign_next     = 1'b0;
                    clean_next    = 1'b1;
                    stop_next     = '0;
                    phase_next    = rlbp_pkg::PH_UPPRE;
                end
                else
                begin
                    do_close = 1'b1;
                end
            end

            if (do_close)
            begin
                close_st = rlbp_pkg::close_status(upper_next, negative_next, number_next,
                                                  lower_next, 8'(TOP_INDEX));
                if (!upper_next)
                begin
                    lower_next = number_next;
                end
                if (close_st != rlbp_pkg::ST_OK)
                begin
                    do_emit     = 1'b1;
                    emit_status = close_st;
                end
                else
                begin
                    bitmap_next = bitmap_next |
                        rlbp_pkg::range_mask(lower_next[5:0], number_next[5:0]);
                    if (after_x)
                    begin
                        do_emit  = 1'b1;
                        emit_pos = (pos != '0) ? pos - CW'(1) : '0;
                    end
                    else if (after_upper && !clean_next)
                    begin
                        do_emit  = 1'b1;
                        emit_pos = stop_next;
                    end
                    else
                    begin
                        phase_next = rlbp_pkg::PH_SEP;
                        do_sep     = 1'b1;
                    end
                end
            end

            if (do_sep)
            begin
                if (c == rlbp_pkg::CH_COMMA || c == rlbp_pkg::CH_SPACE)
                begin
                    phase_next = rlbp_pkg::PH_SEP;
                end
                else if (c inside {[rlbp_pkg::CH_0:rlbp_pkg::CH_9]})
                begin
                    do_begin = 1'b1;
                end
                else
                begin
                    do_emit  = 1'b1;
                    emit_pos = pos;
                end
            end

            if (do_begin)
            begin
                upper_next = begin_upper;
                if (!begin_upper)
                begin
                    negative_next = 1'b0;
                end
                number_next = c - rlbp_pkg::CH_0;
                radix_next  = rlbp_pkg::RADIX_DEC;
                phase_next  = (c == rlbp_pkg::CH_0) ? rlbp_pkg::PH_ZERO : rlbp_pkg::PH_DIGITS;
            end

            if (do_emit)
            begin
                phase_next = rlbp_pkg::PH_IDLE;
            end
        end
    end

    // Offset saturates at the field's top; errors report zero.
    assign emit_pos_w = PW'(emit_pos);

    always_comb
    begin
        result.status    = emit_status;
        result.stave_map = bitmap_next;
        if (emit_status != rlbp_pkg::ST_OK)
        begin
            result.end_offset = '0;
        end
        else if (emit_pos_w > PW'(rlbp_pkg::OFF_MAX))
        begin
            result.end_offset = rlbp_pkg::OFF_W'(rlbp_pkg::OFF_MAX);
        end
        else
        begin
            result.end_offset = emit_pos_w[rlbp_pkg::OFF_W-1:0];
        end
    end

    assign push = accept && do_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= rlbp_pkg::PH_IDLE;
            number_reg   <= '0;
            radix_reg    <= rlbp_pkg::RADIX_DEC;
            negative_reg <= 1'b0;
            lower_reg    <= '0;
            bitmap_reg   <= '0;
            count_reg    <= '0;
            upper_reg    <= 1'b0;
            sign_reg     <= 1'b0;
            clean_reg    <= 1'b1;
            stop_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            number_reg   <= number_next;
            radix_reg    <= radix_next;
            negative_reg <= negative_next;
            lower_reg    <= lower_next;
            bitmap_reg   <= bitmap_next;
            count_reg    <= count_next;
            upper_reg    <= upper_next;
            sign_reg     <= sign_next;
            clean_reg    <= clean_next;
            stop_reg     <= stop_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rlbp_skid.sv
`default_nettype none

`include "assert_macros.svh"

module rlbp_skid (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire rlbp_pkg::map_req_t push_data,
    output logic                    full,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output rlbp_pkg::map_req_t      out_data
);

    logic               out_valid_reg;
    rlbp_pkg::map_req_t out_data_reg;
    logic               skid_valid_reg;
    rlbp_pkg::map_req_t skid_data_reg;
    logic               pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // Drain the skid slot into the output once it frees.
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_reg <= push_data;
            end
            else
            begin
                skid_data_reg <= push_data;
            end
        end
    end

    `RLBP_ASSERT_HOLDS(a_skid_behind_out, !skid_valid_reg || out_valid_reg, "skid without output")
    `RLBP_ASSERT_SAME(a_no_push_when_full, skid_valid_reg, !push, "request pushed while full")
    `RLBP_ASSERT_NEXT(a_skid_fills, push && out_valid_reg && out_stall && !skid_valid_reg, skid_valid_reg, "stalled request lost")

endmodule

`default_nettype wire

### hw/rtl/range_list_to_bitmap_parser.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// char      in         char_valid/char_stall  rlbp_pkg::char_req_t
// map       out        map_valid/map_stall    rlbp_pkg::map_req_t
//
// One character is taken per cycle while char_stall is low; its parse step
// is combinational logic between the parse-state and output registers.
// Results enter the output stage when their ending character is accepted.
// Reset (rst_n low) clears the parse state to idle and empties the output.
// A stalled result is held in a two-entry output stage; char_stall rises
// only when both entries are full.

module range_list_to_bitmap_parser #(
    parameter int TOP_INDEX = rlbp_pkg::TOP_INDEX_DEFAULT,
    parameter int MAX_CHARS = rlbp_pkg::MAX_CHARS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                char_valid,
    output logic                     char_stall,
    input  wire rlbp_pkg::char_req_t char_data,
    output logic                     map_valid,
    input  wire logic                map_stall,
    output rlbp_pkg::map_req_t       map_data
);

    logic               accept;
    logic               push;
    logic               full;
    rlbp_pkg::map_req_t result;

    // Advance the parser on every accepted request.
    assign accept     = char_valid && !char_stall;
    assign char_stall = full;

    rlbp_core #(
        .TOP_INDEX (TOP_INDEX),
        .MAX_CHARS (MAX_CHARS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (char_data),
        .push   (push),
        .result (result)
    );

    // Hold results here while the consumer stalls.
    rlbp_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .full      (full),
        .out_valid (map_valid),
        .out_stall (map_stall),
        .out_data  (map_data)
    );

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rlbp_pkg::*;

    // Parser limits as built with default parameters.
    localparam int TOP_BIT      = TOP_INDEX_DEFAULT;
    localparam int CHAR_LIMIT   = MAX_CHARS_DEFAULT;
    // Receiver hold-off long enough to fill the output stage and stall the input.
    localparam int HOLD_CYCLES  = 300;
    // Settle time after the last expected result, well above the parser's latency.
    localparam int DRAIN_CYCLES = 8;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_LF  = 8'h0A;

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      char_valid = 1'b0;
    logic      char_stall;
    char_req_t char_data  = '0;
    logic      map_valid;
    logic      map_stall  = 1'b0;
    map_req_t  map_data;

    // Traffic shaping: sender idle and receiver stall, in percent.
    int unsigned send_pct  = 0;
    int unsigned stall_pct = 0;
    logic        hold_arm  = 1'b0;
    int unsigned hold_left = 0;

    int unsigned err_count  = 0;
    int unsigned item_count = 0;

    // Maps the parser still owes us, oldest first.
    map_req_t    map_expect_q[$];
    map_req_t    map_want;
    // Characters of the list being built, sent in order.
    logic [7:0]  text_q[$];

    // Shadow parse state.
    phase_t      pr_phase;
    logic [7:0]  pr_value;
    radix_t      pr_radix;
    logic        pr_negative;
    logic [7:0]  pr_lower;
    logic [63:0] pr_map;
    int unsigned pr_count;
    logic        pr_upper;
    logic        pr_sign_taken;
    logic        pr_plain;
    int unsigned pr_stop;

    always #1 clk = ~clk;

    range_list_to_bitmap_parser u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .map_valid  (map_valid),
        .map_stall  (map_stall),
        .map_data   (map_data)
    );

    // ------------------------------------------------------------------
    // Shadow parser: computes the map, status and end offset per list.
    // ------------------------------------------------------------------

    function automatic void clear_parse();
        pr_phase      = PH_IDLE;
        pr_value      = '0;
        pr_radix      = RADIX_DEC;
        pr_negative   = 1'b0;
        pr_lower      = '0;
        pr_map        = '0;
        pr_count      = 0;
        pr_upper      = 1'b0;
        pr_sign_taken = 1'b0;
        pr_plain      = 1'b1;
        pr_stop       = 0;
    endfunction

    function automatic bit is_dec(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Base-16 digit value, 16 for anything else.
    function automatic int unsigned hex_val(input logic [7:0] c);
        if (is_dec(c))
            return c - CH_0;
        if (c >= CH_LC_A && c <= CH_LC_F)
            return c - CH_LC_A + 10;
        if (c >= CH_UC_A && c <= CH_UC_F)
            return c - CH_UC_A + 10;
        return 16;
    endfunction

    // The list is over: queue the map it should produce and go idle.
    function automatic void list_done(input logic [1:0] st, input int unsigned pos);
        map_req_t r;
        r.status     = st;
        r.stave_map  = pr_map;
        r.end_offset = (st != ST_OK) ? '0 : OFF_W'(pos > OFF_MAX ? OFF_MAX : pos);
        map_expect_q.push_back(r);
        pr_phase = PH_IDLE;
    endfunction

    function automatic void start_number(input logic [7:0] c, input logic upper);
        pr_upper = upper;
        if (!upper)
            pr_negative = 1'b0;
        pr_value = c - CH_0;
        pr_radix = RADIX_DEC;
        pr_phase = (c == CH_0) ? PH_ZERO : PH_DIGITS;
    endfunction

    // Finish the current entry; set its bits only when it is legal.
    function automatic logic [1:0] close_range();
        int unsigned lo;
        int unsigned hi;
        if (!pr_upper)
        begin
            pr_lower = pr_value;
            lo = pr_value;
            hi = pr_value;
        end
        else
        begin
            lo = pr_lower;
            if (pr_negative && pr_value != 0)
                return ST_BACKWARD;
            hi = pr_value;
            if (hi < lo)
                return ST_BACKWARD;
        end
        if (hi > TOP_BIT)
            return ST_TOO_HIGH;
        for (int unsigned i = lo; i <= hi; i++)
            pr_map[i] = 1'b1;
        return ST_OK;
    endfunction

    function automatic void between_entries(input logic [7:0] c, input int unsigned pos);
        if (c == CH_COMMA || c == CH_SPACE)
            pr_phase = PH_SEP;
        else if (is_dec(c))
            start_number(c, 1'b0);
        else
            list_done(ST_OK, pos);
    endfunction

    function automatic void after_number(input logic [7:0] c, input int unsigned pos);
        logic [1:0] st;
        if (!pr_upper && c == CH_DASH)
        begin
            pr_lower      = pr_value;
            pr_upper      = 1'b1;
            pr_negative   = 1'b0;
            pr_sign_taken = 1'b0;
            pr_plain      = 1'b1;
            pr_stop       = 0;
            pr_phase      = PH_UPPRE;
            return;
        end
        st = close_range();
        if (st != ST_OK)
        begin
            list_done(st, 0);
        end
        else
        begin
            pr_phase = PH_SEP;
            between_entries(c, pos);
        end
    endfunction

    // Advance the shadow state by one accepted request; 0 when it is ignored.
    function automatic bit predict_char(input logic first, input logic [7:0] c);
        int unsigned pos;
        int unsigned d;
        int unsigned base;
        int unsigned v;
        logic [1:0]  st;
        if (first)
        begin
            clear_parse();
            pr_phase = PH_START;
        end
        if (pr_phase == PH_IDLE)
            return 1'b0;
        pos = pr_count;
        if (pr_count < CHAR_LIMIT)
            pr_count++;
        case (pr_phase)
            PH_START:
            begin
                if (is_dec(c))
                    start_number(c, 1'b0);
                else
                    list_done(ST_OK, pos);
            end
            PH_SEP: between_entries(c, pos);
            PH_ZERO:
            begin
                if (c == CH_LC_X || c == CH_UC_X)
                begin
                    pr_phase = PH_X;
                end
                else if (c >= CH_0 && c <= CH_7)
                begin
                    pr_radix = RADIX_OCT;
                    pr_value = c - CH_0;
                    pr_phase = PH_DIGITS;
                end
                else
                begin
                    after_number(c, pos);
                end
            end
            PH_X:
            begin
                d = hex_val(c);
                if (d < 16)
                begin
                    pr_radix = RADIX_HEX;
                    pr_value = 8'(d);
                    pr_phase = PH_DIGITS;
                end
                else
                begin
                    // Bare prefix reads as zero; the list ends at the 'x'.
                    pr_value = '0;
                    st = close_range();
                    list_done(st, pos > 0 ? pos - 1 : 0);
                end
            end
            PH_DIGITS:
            begin
                d = hex_val(c);
                base = (pr_radix == RADIX_HEX) ? 16 : (pr_radix == RADIX_OCT ? 8 : 10);
                if (d < base)
                begin
                    v = int'(pr_value) * base + d;
                    pr_value = (v > 255) ? 8'd255 : v[7:0];
                end
                else
                begin
                    after_number(c, pos);
                end
            end
            PH_UPPRE:
            begin
                if (!pr_sign_taken && is_blank(c))
                begin
                    if (c != CH_SPACE && pr_plain)
                    begin
                        pr_plain = 1'b0;
                        pr_stop  = pos;
                    end
                end
                else if (!pr_sign_taken && (c == CH_PLUS || c == CH_DASH))
                begin
                    pr_sign_taken = 1'b1;
                    pr_negative   = (c == CH_DASH);
                    if (pr_plain)
                    begin
                        pr_plain = 1'b0;
                        pr_stop  = pos;
                    end
                end
                else if (is_dec(c))
                begin
                    start_number(c, 1'b1);
                end
                else
                begin
                    // No digits after the dash: the bound is zero.
                    pr_value    = '0;
                    pr_negative = 1'b0;
                    st = close_range();
                    if (st != ST_OK)
                    begin
                        list_done(st, 0);
                    end
                    else if (!pr_plain)
                    begin
                        list_done(ST_OK, pr_stop);
                    end
                    else
                    begin
                        pr_phase = PH_SEP;
                        between_entries(c, pos);
                    end
                end
            end
            default: pr_phase = PH_IDLE;
        endcase
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stall, or a long hold-off once armed.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            map_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_arm)
        begin
            map_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_arm  <= 1'b0;
        end
        else
        begin
            map_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Result checker: each accepted map request against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && map_valid && !map_stall)
        begin
            if (map_expect_q.size() == 0)
            begin
                $display("%0t: unexpected map request status=%0d map=%h offset=%0d",
                         $time, map_data.status, map_data.stave_map, map_data.end_offset);
                err_count++;
            end
            else
            begin
                map_want = map_expect_q.pop_front();
                if (map_data.status !== map_want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, map_want.status, map_data.status);
                    err_count++;
                end
                if (map_data.stave_map !== map_want.stave_map)
                begin
                    $display("%0t: stave_map expected %h actual %h",
                             $time, map_want.stave_map, map_data.stave_map);
                    err_count++;
                end
                if (map_data.end_offset !== map_want.end_offset)
                begin
                    $display("%0t: end_offset expected %0d actual %0d",
                             $time, map_want.end_offset, map_data.end_offset);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one character request; hold it until the parser takes it.
    // Valid stays high afterwards so back-to-back requests need no extra edge.
    task automatic send_char(input logic first, input logic [7:0] code);
        while ($urandom_range(99) < send_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= '{first_char: first, char_code: code};
        do
            @(posedge clk);
        while (char_stall);
        if (predict_char(first, code))
            item_count++;
    endtask

    // Drop valid and wait until every expected map has come back.
    task automatic wait_drain();
        char_valid <= 1'b0;
        while (map_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    // Send the built text as one list: only its first character restarts the parser.
    task automatic send_queued();
        for (int i = 0; i < text_q.size(); i++)
            send_char(i == 0, text_q[i]);
        text_q.delete();
    endtask

    task automatic send_list(input string s);
        push_text(s);
        send_queued();
    endtask

    // Mostly legal indices, some just above the top, a few that saturate.
    function automatic int unsigned pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 75)
            return $urandom_range(TOP_BIT);
        if (r < 90)
            return $urandom_range(300, TOP_BIT + 1);
        return $urandom_range(99999, 300);
    endfunction

    // Append a number in decimal, hex (either prefix and digit case) or octal.
    task automatic push_number(input int unsigned v);
        string       s;
        int unsigned form;
        form = $urandom_range(9);
        if (form < 6)
        begin
            s = $sformatf("%0d", v);
        end
        else if (form < 8)
        begin
            s = $sformatf("%0h", v);
            for (int i = 0; i < s.len(); i++)
                if (s[i] >= CH_LC_A && $urandom_range(1))
                    s[i] = s[i] - 8'd32;
            s = {($urandom_range(1) ? "0x" : "0X"), s};
        end
        else
        begin
            s = {"0", $sformatf("%0o", v)};
        end
        push_text(s);
    endtask

    // Build one well-formed list with random entries and a random ending, or none.
    task automatic build_list();
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        int unsigned k;
        n = $urandom_range(4, 1);
        for (int e = 0; e < n; e++)
        begin
            lo = pick_value();
            push_number(lo);
            if ($urandom_range(2) == 0)
            begin
                text_q.push_back(CH_DASH);
                k = $urandom_range(19);
                case (k)
                    0: text_q.push_back(CH_SPACE);
                    1: text_q.push_back(CH_TAB);
                    2: text_q.push_back(CH_PLUS);
                    3: text_q.push_back(CH_DASH);
                    default: ;
                endcase
                // Leave the bound out now and then.
                if (k != 4)
                begin
                    hi = ($urandom_range(4) == 0) ? pick_value() : lo + $urandom_range(10);
                    push_number(hi);
                end
            end
            if (e + 1 < n)
            begin
                case ($urandom_range(3))
                    0: text_q.push_back(CH_COMMA);
                    1: text_q.push_back(CH_SPACE);
                    2: push_text(", ");
                    default: push_text(",,");
                endcase
            end
        end
        case ($urandom_range(9))
            0, 1, 2: text_q.push_back(CH_NUL);
            3: push_text(";");
            4: text_q.push_back(CH_LF);
            5: push_text("z");
            6, 7, 8: text_q.push_back(8'($urandom_range(255)));
            default: ;  // leave it unfinished; the next list restarts the parser
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Characters before any list starts are dropped without a result.
    task automatic test_idle_stream();
        send_char(1'b0, "7");
        send_char(1'b0, CH_COMMA);
        send_char(1'b0, 8'hFF);
        wait_drain();
    endtask

    task automatic test_basic_lists();
        push_text("1,3,4-6,10");
        text_q.push_back(CH_NUL);
        send_queued();
        send_list("0-63;");     // full map, top index
        send_list("a");         // empty list
        send_char(1'b0, "5");   // trailing character after the list: ignored
        wait_drain();
    endtask

    task automatic test_special_forms();
        send_list("08 0x;");        // octal stops at 8; bare hex prefix
        send_list("64,");           // above the top index
        send_list("7-3,");          // backward range
        send_list("0-,5x");         // upper bound with no digits, then more
        send_list("0-\t;");         // tab after dash ends the list there
        send_list("0--0,4-+5-");    // negative zero and explicit plus
        send_list("3- -2");         // negative bound
        send_list("999-777,");      // both saturate
        push_text("0XaB");
        text_q.push_back(CH_NUL);
        send_queued();
        send_list("12");            // unfinished, restarted below
        send_list("077;");
        wait_drain();
    endtask

    // Offsets past the character limit saturate.
    task automatic test_long_list();
        text_q.push_back("1");
        repeat (CHAR_LIMIT + 4) text_q.push_back(CH_SPACE);
        push_text(";");
        send_queued();
        wait_drain();
    endtask

    // Hold the receiver off while short lists keep coming, so the output stage
    // fills and the parser stalls its input; then pause until all is back.
    task automatic test_backpressure();
        send_pct = 0;
        stall_pct <= 0;
        hold_arm  <= 1'b1;
        repeat (20)
        begin
            push_number($urandom_range(TOP_BIT));
            push_text(";");
            send_queued();
        end
        wait_drain();
    endtask

    task automatic test_random(input int unsigned idle, input int unsigned stall,
                               input int unsigned budget);
        int unsigned stop_at;
        int unsigned k;
        send_pct = idle;
        stall_pct <= stall;
        stop_at = item_count + budget;
        while (item_count < stop_at)
        begin
            if ($urandom_range(99) < 12)
            begin
                // Noise: raw bytes, sometimes restarting a list.
                k = $urandom_range(6, 1);
                repeat (k) send_char($urandom_range(4) == 0, 8'($urandom_range(255)));
            end
            else
            begin
                build_list();
                send_queued();
            end
        end
        wait_drain();
    endtask

    initial
    begin
        clear_parse();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_idle_stream();
        test_basic_lists();
        test_special_forms();
        test_long_list();
        test_backpressure();
        test_random(0, 0, 80);
        test_random(67, 0, 80);
        test_random(0, 67, 80);
        test_random(11, 11, 60);

        wait_drain();
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("%0t: timeout, %0d maps still expected", $time, map_expect_q.size());
        $display("FAIL");
        $finish;
    end

endmodule
